[rtl/vtf_pkg.sv]
// ----------------------------------------------------------------------------
// vtf_pkg
// Shared types and constants of the virtual time fair gate: field widths,
// request opcodes, controller states and the per-cell command.
// ----------------------------------------------------------------------------
`default_nettype none

package vtf_pkg;

  localparam int CostW      = 32;
  localparam int WeightW    = 9;
  localparam int WeightFrac = 8;
  localparam int StampW     = 48;
  localparam int CntW       = 32;
  localparam int PeriodW    = 32;
  localparam int IdW        = 2;
  localparam int LeaderW    = 2;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 32;
  localparam int ProdW      = CostW + WeightW;
  localparam int IncW       = ProdW - WeightFrac;

  localparam int InDataW    = 136;
  localparam int OutDataW   = 72;

  localparam int NumWeightRegs = 4;

  localparam logic [WeightW-1:0] WeightOne   = 9'd256;
  localparam logic [PeriodW-1:0] PeriodReset = 32'd200000000;
  localparam logic [CfgIdxW-1:0] CfgIdxPeriod = 3'd4;

  typedef enum logic {
    OP_UPDATE   = 1'b0,
    OP_RESAMPLE = 1'b1
  } vtf_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCALE,
    ST_APPLY,
    ST_SCAN,
    ST_RESP
  } vtf_state_e;

  typedef struct packed {
    logic add_inc;
    logic cnt_accept;
    logic cnt_drop;
    logic rebase;
  } vtf_cell_cmd_t;

endpackage

`default_nettype wire

[rtl/vtf_cell.sv]
// ----------------------------------------------------------------------------
// vtf_cell
// One source entry: virtual time, saturating accept and drop counters, and
// one stage of the minimum scan that passes toward the next cell each cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vtf_cell
  import vtf_pkg::*;
#(
  parameter int TIME_BITS = 48,
  parameter int IDX_W     = 2,
  parameter int CELL_IDX  = 0
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire vtf_cell_cmd_t        cmd_i,
  input  wire logic [TIME_BITS-1:0] inc_i,
  input  wire logic [TIME_BITS-1:0] base_i,
  input  wire logic [TIME_BITS-1:0] prev_val_i,
  input  wire logic [IDX_W-1:0]     prev_idx_i,
  output logic [TIME_BITS-1:0]      vt_o,
  output logic [CntW-1:0]           drop_cnt_o,
  output logic [CntW-1:0]           accept_cnt_o,
  output logic [TIME_BITS-1:0]      scan_val_o,
  output logic [IDX_W-1:0]          scan_idx_o
);

  logic [TIME_BITS-1:0] vt_q, vt_d;
  logic [CntW-1:0]      drop_q, drop_d;
  logic [CntW-1:0]      acc_q, acc_d;
  logic [TIME_BITS-1:0] scan_val_q, scan_val_d;
  logic [IDX_W-1:0]     scan_idx_q, scan_idx_d;
  logic [TIME_BITS:0]   sum;

  assign sum = {1'b0, vt_q} + {1'b0, inc_i};

  always_comb begin
    vt_d = vt_q;
    if (cmd_i.add_inc) begin
      vt_d = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
    end else if (cmd_i.rebase) begin
      vt_d = vt_q - base_i;
    end
    acc_d  = (cmd_i.cnt_accept && acc_q != {CntW{1'b1}}) ? acc_q + 1'b1 : acc_q;
    drop_d = (cmd_i.cnt_drop && drop_q != {CntW{1'b1}}) ? drop_q + 1'b1 : drop_q;
    // strict compare keeps ties on the lower index
    if (CELL_IDX == 0 || vt_q < prev_val_i) begin
      scan_val_d = vt_q;
      scan_idx_d = IDX_W'(CELL_IDX);
    end else begin
      scan_val_d = prev_val_i;
      scan_idx_d = prev_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vt_q       <= '0;
      drop_q     <= '0;
      acc_q      <= '0;
      scan_val_q <= '0;
      scan_idx_q <= '0;
    end else begin
      vt_q       <= vt_d;
      drop_q     <= drop_d;
      acc_q      <= acc_d;
      scan_val_q <= scan_val_d;
      scan_idx_q <= scan_idx_d;
    end
  end

  assign vt_o         = vt_q;
  assign drop_cnt_o   = drop_q;
  assign accept_cnt_o = acc_q;
  assign scan_val_o   = scan_val_q;
  assign scan_idx_o   = scan_idx_q;

endmodule

`default_nettype wire

[rtl/virtual_time_fair_gate_unit.sv]
// ----------------------------------------------------------------------------
// virtual_time_fair_gate_unit
// Fair-share gate over NUM_SOURCES sources kept by virtual time, built as a
// row of source cells with a systolic minimum scan.
//
//   channel  | direction | payload
//   s_axis   | in        | tuser: opcode; tdata: source_id, stamp_ns, now_ns, cost_ns
//   m_axis   | out       | tuser: accepted; tdata: leader_id, dropped_count,
//            |           |        accepted_count
//   cfg      | in        | cfg_index_i: register index, cfg_data_i: value
//
// accepted update: decide, scale and apply steps, then the scan through the
//   cell row (one cell per cycle), then the response step
// dropped update or granted resample: decide, apply and response steps
// refused resample or update from a source out of range: decide and response steps
// a new request is taken once the result is in the output register
// reset clears all virtual times, counters and deadlines and sets every
//   weight back to one
// a stalled output holds the controller in its response step
// ----------------------------------------------------------------------------
`default_nettype none

module virtual_time_fair_gate_unit
  import vtf_pkg::*;
#(
  parameter int NUM_SOURCES = 4,
  parameter int TIME_BITS   = 48
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // [1:0] source_id, [49:2] stamp_ns, [97:50] now_ns, [129:98] cost_ns
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // [0] opcode
  input  wire logic                s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [1:0] leader_id, [33:2] dropped_count, [65:34] accepted_count
  output logic [OutDataW-1:0]      m_axis_tdata,
  // [0] accepted
  output logic                     m_axis_tuser,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  localparam int IdxW = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int SatW = (TIME_BITS > IncW) ? TIME_BITS : IncW;

  vtf_state_e           state_q, state_d;
  vtf_op_e              op_q;
  logic [IdW-1:0]       id_q;
  logic [TIME_BITS-1:0] stamp_q, now_q;
  logic [CostW-1:0]     cost_q;
  logic                 ok_q, ok_d;
  logic [ProdW-1:0]     prod_q, prod_d;
  logic [TIME_BITS-1:0] inc_q, inc_d;
  logic [TIME_BITS-1:0] minv_q, minv_d;
  logic [IdxW-1:0]      scan_cnt_q, scan_cnt_d;
  logic [IdxW-1:0]      leader_q, leader_d;
  logic [TIME_BITS-1:0] last_time_q, last_time_d;
  logic                 last_valid_q, last_valid_d;
  logic [TIME_BITS-1:0] dl_q, dl_d;
  logic                 dl_valid_q, dl_valid_d;
  logic                 allow_q, allow_d;
  logic [WeightW-1:0]   weight_q [NumWeightRegs];
  logic [PeriodW-1:0]   period_q;
  logic                 m_valid_q, m_valid_d;
  logic [OutDataW-1:0]  m_tdata_q, m_tdata_d;
  logic                 m_tuser_q, m_tuser_d;

  logic [TIME_BITS-1:0] vt       [NUM_SOURCES];
  logic [CntW-1:0]      drop_cnt [NUM_SOURCES];
  logic [CntW-1:0]      acc_cnt  [NUM_SOURCES];
  logic [TIME_BITS-1:0] scan_val [NUM_SOURCES];
  logic [IdxW-1:0]      scan_idx [NUM_SOURCES];
  vtf_cell_cmd_t        cmd      [NUM_SOURCES];

  logic                 in_range;
  logic [IdxW-1:0]      id_sel;
  logic [TIME_BITS-1:0] eff_last, eff_dl, vt_lead;
  logic [TIME_BITS:0]   dl_sum;
  logic [SatW-1:0]      inc_wide, mask_wide;
  logic                 apply_upd, apply_drop, apply_rebase;
  logic                 in_fire;
  logic [WeightW-1:0]   cfg_weight;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;

  assign in_range  = (32'(id_q) < 32'(NUM_SOURCES));
  assign id_sel    = IdxW'(id_q);
  assign eff_last  = last_valid_q ? last_time_q : now_q;
  assign eff_dl    = dl_valid_q ? dl_q : now_q;
  assign dl_sum    = {1'b0, now_q} + (TIME_BITS + 1)'(period_q);
  assign vt_lead   = vt[leader_q];
  assign inc_wide  = SatW'(prod_q[ProdW-1:WeightFrac]);
  assign mask_wide = SatW'({TIME_BITS{1'b1}});

  // cell row
  for (genvar i = 0; i < NUM_SOURCES; i++) begin : g_cell
    logic [TIME_BITS-1:0] prev_val;
    logic [IdxW-1:0]      prev_idx;
    if (i == 0) begin : g_head
      assign prev_val = '0;
      assign prev_idx = '0;
    end else begin : g_body
      assign prev_val = scan_val[i-1];
      assign prev_idx = scan_idx[i-1];
    end

    always_comb begin
      cmd[i].add_inc    = apply_upd && (id_sel == IdxW'(i));
      cmd[i].cnt_accept = apply_upd && (id_sel == IdxW'(i));
      cmd[i].cnt_drop   = apply_drop && (id_sel == IdxW'(i));
      cmd[i].rebase     = apply_rebase;
    end

    vtf_cell #(
      .TIME_BITS(TIME_BITS),
      .IDX_W    (IdxW),
      .CELL_IDX (i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd[i]),
      .inc_i       (inc_q),
      .base_i      (minv_q),
      .prev_val_i  (prev_val),
      .prev_idx_i  (prev_idx),
      .vt_o        (vt[i]),
      .drop_cnt_o  (drop_cnt[i]),
      .accept_cnt_o(acc_cnt[i]),
      .scan_val_o  (scan_val[i]),
      .scan_idx_o  (scan_idx[i])
    );
  end

  // controller
  always_comb begin
    state_d      = state_q;
    ok_d         = ok_q;
    prod_d       = prod_q;
    inc_d        = inc_q;
    minv_d       = minv_q;
    scan_cnt_d   = scan_cnt_q;
    leader_d     = leader_q;
    last_time_d  = last_time_q;
    last_valid_d = last_valid_q;
    dl_d         = dl_q;
    dl_valid_d   = dl_valid_q;
    allow_d      = allow_q;
    m_tdata_d    = m_tdata_q;
    m_tuser_d    = m_tuser_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    apply_upd    = 1'b0;
    apply_drop   = 1'b0;
    apply_rebase = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        prod_d = ProdW'(cost_q) * ProdW'(weight_q[id_q]);
        minv_d = vt_lead;
        if (op_q == OP_UPDATE) begin
          ok_d = in_range && (id_sel == leader_q) && (stamp_q >= eff_last);
          if (in_range) begin
            last_valid_d = 1'b1;
            last_time_d  = ok_d ? now_q : eff_last;
            if (ok_d) begin
              allow_d = 1'b1;
              state_d = ST_SCALE;
            end else begin
              state_d = ST_APPLY;
            end
          end else begin
            state_d = ST_RESP;
          end
        end else begin
          ok_d       = allow_q && (eff_dl < stamp_q);
          dl_valid_d = 1'b1;
          dl_d       = eff_dl;
          if (ok_d) begin
            dl_d    = dl_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : dl_sum[TIME_BITS-1:0];
            allow_d = 1'b0;
            state_d = ST_APPLY;
          end else begin
            state_d = ST_RESP;
          end
        end
      end
      ST_SCALE: begin
        inc_d   = (inc_wide > mask_wide) ? {TIME_BITS{1'b1}} : TIME_BITS'(inc_wide);
        state_d = ST_APPLY;
      end
      ST_APPLY: begin
        if (op_q == OP_UPDATE) begin
          apply_upd  = ok_q;
          apply_drop = !ok_q;
        end else begin
          apply_rebase = 1'b1;
        end
        scan_cnt_d = '0;
        state_d    = (op_q == OP_UPDATE && ok_q) ? ST_SCAN : ST_RESP;
      end
      ST_SCAN: begin
        scan_cnt_d = scan_cnt_q + 1'b1;
        if (scan_cnt_q == IdxW'(NUM_SOURCES - 1)) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!m_valid_q || m_axis_tready) begin
          if (op_q == OP_UPDATE && ok_q) begin
            leader_d = scan_idx[NUM_SOURCES-1];
          end
          m_tuser_d = ok_q;
          m_tdata_d = '0;
          m_tdata_d[LeaderW-1:0] = LeaderW'(leader_d);
          if (op_q == OP_UPDATE && in_range) begin
            m_tdata_d[LeaderW+CntW-1:LeaderW]        = drop_cnt[id_sel];
            m_tdata_d[LeaderW+2*CntW-1:LeaderW+CntW] = acc_cnt[id_sel];
          end
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q         <= 1'b0;
      scan_cnt_q   <= '0;
      leader_q     <= '0;
      last_time_q  <= '0;
      last_valid_q <= 1'b0;
      dl_q         <= '0;
      dl_valid_q   <= 1'b0;
      allow_q      <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      ok_q         <= ok_d;
      scan_cnt_q   <= scan_cnt_d;
      leader_q     <= leader_d;
      last_time_q  <= last_time_d;
      last_valid_q <= last_valid_d;
      dl_q         <= dl_d;
      dl_valid_q   <= dl_valid_d;
      allow_q      <= allow_d;
      m_valid_q    <= m_valid_d;
    end
  end

  // request and arithmetic payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q    <= vtf_op_e'(s_axis_tuser);
      id_q    <= s_axis_tdata[IdW-1:0];
      stamp_q <= TIME_BITS'(s_axis_tdata[IdW+StampW-1:IdW]);
      now_q   <= TIME_BITS'(s_axis_tdata[IdW+2*StampW-1:IdW+StampW]);
      cost_q  <= s_axis_tdata[IdW+2*StampW+CostW-1:IdW+2*StampW];
    end
    prod_q    <= prod_d;
    inc_q     <= inc_d;
    minv_q    <= minv_d;
    m_tdata_q <= m_tdata_d;
    m_tuser_q <= m_tuser_d;
  end

  // configuration registers
  assign cfg_weight = (cfg_data_i[WeightW-1:0] > WeightOne) ? WeightOne
                                                            : cfg_data_i[WeightW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumWeightRegs; k++) begin
        weight_q[k] <= WeightOne;
      end
      period_q <= PeriodReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (32'(cfg_index_i) < 32'(NumWeightRegs) && 32'(cfg_index_i) < 32'(NUM_SOURCES)) begin
        weight_q[cfg_index_i[IdW-1:0]] <= cfg_weight;
      end else if (cfg_index_i == CfgIdxPeriod) begin
        period_q <= cfg_data_i;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tuser  = m_tuser_q;

  // assertions
  a_accept_to_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == ST_DECIDE)
    else $error("request accepted but controller did not start");

  a_grant_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_APPLY && ok_q && op_q == OP_UPDATE) |=> state_q == ST_SCAN)
    else $error("granted update skipped the leader scan");

  a_allow_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(allow_q) |-> $past(state_q == ST_DECIDE && op_q == OP_RESAMPLE))
    else $error("resample permission cleared outside a resample");

  for (genvar i = 0; i < NUM_SOURCES; i++) begin : g_chk
    a_leader_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
      state_q == ST_IDLE |-> vt_lead <= vt[i])
      else $error("leader does not hold the smallest virtual time");
  end

endmodule

`default_nettype wire
